FILE: hw/rtl/hsc_pkg.sv
// shared types, codes and bit-placement functions for the hamming sec codec
package hsc_pkg;

	localparam int MAX_DATA_BITS = 57;
	localparam int WORD_W        = 63;
	localparam int KW            = 6;
	localparam int SYN_W         = 6;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	localparam logic [1:0] ST_CLEAN   = 2'd0;
	localparam logic [1:0] ST_PARITY  = 2'd1;
	localparam logic [1:0] ST_FIXED   = 2'd2;
	localparam logic [1:0] ST_UNCORR  = 2'd3;

	localparam logic [KW-1:0] DATA_BITS_RST = KW'(4);
	localparam logic [KW-1:0] DATA_BITS_MAX = KW'(MAX_DATA_BITS);

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [1:0]        status;
	} hsc_result_t;

	// codeword length for a (clamped) data length
	function automatic logic [KW-1:0] code_len(logic [KW-1:0] k);
		logic [KW-1:0] r;
		case (k) inside
			6'd0:         r = 6'd0;
			6'd1:         r = 6'd2;
			[6'd2:6'd4]:  r = 6'd3;
			[6'd5:6'd11]: r = 6'd4;
			[6'd12:6'd26]: r = 6'd5;
			default:      r = 6'd6;
		endcase
		return (k == 6'd0) ? 6'd0 : k + r;
	endfunction

	// data bit j to the j-th non power-of-two position
	function automatic logic [WORD_W-1:0] scatter(logic [WORD_W-1:0] d);
		logic [WORD_W-1:0] cw;
		int j;
		cw = '0;
		j  = 0;
		for (int p = 1; p <= WORD_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				cw[p-1] = d[j];
				j++;
			end
		end
		return cw;
	endfunction

	// inverse of scatter
	function automatic logic [WORD_W-1:0] gather(logic [WORD_W-1:0] cw);
		logic [WORD_W-1:0] d;
		int j;
		d = '0;
		j = 0;
		for (int p = 1; p <= WORD_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				d[j] = cw[p-1];
				j++;
			end
		end
		return d;
	endfunction

	// even-parity checks, bit i covers positions with index bit i set
	function automatic logic [SYN_W-1:0] syndrome(logic [WORD_W-1:0] cw);
		logic [SYN_W-1:0] s;
		s = '0;
		for (int i = 0; i < SYN_W; i++) begin
			for (int p = 1; p <= WORD_W; p++) begin
				if (((p >> i) & 1) != 0)
					s[i] = s[i] ^ cw[p-1];
			end
		end
		return s;
	endfunction

endpackage

FILE: hw/rtl/hsc_if.sv
// valid/ready channel interfaces for request and result words
interface hsc_req_if;
	logic                           valid;
	logic                           ready;
	logic                           command;
	logic [hsc_pkg::WORD_W-1:0]     word_in;

	modport source (output valid, output command, output word_in, input ready);
	modport sink   (input valid, input command, input word_in, output ready);
endinterface

interface hsc_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [hsc_pkg::WORD_W-1:0]     word_out;
	logic [1:0]                     status;

	modport source (output valid, output word_out, output status, input ready);
	modport sink   (input valid, input word_out, input status, output ready);
endinterface

FILE: hw/rtl/hamming_sec_codec_core.sv
// top level: input register, codec logic, result register
//
// channel  dir  fields                 meaning
// req      in   command, word_in       encode data word or decode codeword
// rsp      out  word_out, status       codeword or extracted data, check status
// cfg      in   cfg_we, cfg_wdata      data length register
//
// one word per cycle sustained while rsp.ready stays high; rsp.valid follows the req accept
// through the input register and the result register around the codec logic
// rsp stall backs up into the input register, req.ready drops when both hold a word
// and rsp.ready is low
// arst_n clears both valid flags and sets the data length to 4
module hamming_sec_codec_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [hsc_pkg::KW-1:0] cfg_wdata,
	hsc_req_if.sink                req,
	hsc_rsp_if.source              rsp
);

	logic [hsc_pkg::KW-1:0]     data_bits_q;
	logic [hsc_pkg::KW-1:0]     k;
	logic                       valid_s1;
	logic                       cmd_s1;
	logic [hsc_pkg::WORD_W-1:0] word_s1;
	logic                       valid_s2;
	logic                       cmd_s2;
	hsc_pkg::hsc_result_t       res;
	hsc_pkg::hsc_result_t       res_s2;
	logic                       adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			data_bits_q <= hsc_pkg::DATA_BITS_RST;
		else if (cfg_we)
			data_bits_q <= cfg_wdata;
	end

	assign k = (data_bits_q > hsc_pkg::DATA_BITS_MAX) ? hsc_pkg::DATA_BITS_MAX : data_bits_q;

	assign adv_s1    = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (adv_s1)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1  <= req.command;
			word_s1 <= req.word_in;
		end
		if (valid_s1 && adv_s1) begin
			cmd_s2 <= cmd_s1;
			res_s2 <= res;
		end
	end

	hsc_codec u_codec (
		.command (cmd_s1),
		.word    (word_s1),
		.k       (k),
		.result  (res)
	);

	assign rsp.valid    = valid_s2;
	assign rsp.word_out = res_s2.word;
	assign rsp.status   = res_s2.status;

	a_enc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && cmd_s2 == hsc_pkg::CMD_ENCODE |->
		res_s2.status == hsc_pkg::ST_CLEAN && hsc_pkg::syndrome(res_s2.word) == '0)
		else $error("encoded word fails its own parity checks");

	a_out_width: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && cmd_s2 == hsc_pkg::CMD_DECODE |->
		(res_s2.word & ({hsc_pkg::WORD_W{1'b1}} << k)) == '0)
		else $error("decoded word has bits beyond the data length");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(word_s1) && $stable(cmd_s1))
		else $error("input register lost a stalled word");

	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted word not captured");

endmodule

FILE: hw/rtl/hsc_codec.sv
// combinational encode/check/correct logic for one word
module hsc_codec (
	input  logic                           command,
	input  logic [hsc_pkg::WORD_W-1:0]     word,
	input  logic [hsc_pkg::KW-1:0]         k,
	output hsc_pkg::hsc_result_t           result
);

	logic [hsc_pkg::KW-1:0]     n;
	logic [hsc_pkg::WORD_W-1:0] kmask;
	logic [hsc_pkg::WORD_W-1:0] nmask;
	logic [hsc_pkg::WORD_W-1:0] enc;
	logic [hsc_pkg::SYN_W-1:0]  enc_par;
	logic [hsc_pkg::WORD_W-1:0] w;
	logic [hsc_pkg::SYN_W-1:0]  s;
	logic [2:0]                 fails;
	logic [hsc_pkg::WORD_W-1:0] fixed;

	assign n     = hsc_pkg::code_len(k);
	assign kmask = ~({hsc_pkg::WORD_W{1'b1}} << k);
	assign nmask = ~({hsc_pkg::WORD_W{1'b1}} << n);

	always_comb begin
		enc     = hsc_pkg::scatter(word & kmask);
		enc_par = hsc_pkg::syndrome(enc);
		for (int i = 0; i < hsc_pkg::SYN_W; i++)
			enc[(1 << i) - 1] = enc_par[i];
	end

	assign w     = word & nmask;
	assign s     = hsc_pkg::syndrome(w);
	assign fails = 3'($countones(s));
	assign fixed = w ^ ({{(hsc_pkg::WORD_W-1){1'b0}}, 1'b1} << (s - 6'd1));

	always_comb begin
		if (command == hsc_pkg::CMD_ENCODE) begin
			result.word   = enc;
			result.status = hsc_pkg::ST_CLEAN;
		end else if (fails == 3'd0) begin
			result.word   = hsc_pkg::gather(w);
			result.status = hsc_pkg::ST_CLEAN;
		end else if (fails == 3'd1) begin
			result.word   = hsc_pkg::gather(w);
			result.status = hsc_pkg::ST_PARITY;
		end else if (s > n) begin
			result.word   = hsc_pkg::gather(w);
			result.status = hsc_pkg::ST_UNCORR;
		end else begin
			result.word   = hsc_pkg::gather(fixed);
			result.status = hsc_pkg::ST_FIXED;
		end
	end

endmodule
